// ===== rtl/gic_pkg.sv =====
// Shared types and constants for the gamepad input conditioner.
// No dependencies; used by gic_div, gic_sqrt and the top level by scoped names.
`default_nettype none
package gic_pkg;

  localparam int NUM_PADS = 4;
  localparam int PAD_W    = 2;
  localparam int ADDR_W   = 4;

  localparam logic [15:0] BUTTON_MASK = 16'hF3FF;
  localparam logic [14:0] FULL_SCALE  = 15'd32767;

  localparam int NUM_W  = 55;
  localparam int DEN_W  = 40;
  localparam int QUOT_W = 18;
  localparam int RAD_W  = 48;
  localparam int ROOT_W = 24;

  localparam logic [1:0] REG_TRIG_THR = 2'd0;
  localparam logic [1:0] REG_LEFT_DZ  = 2'd1;
  localparam logic [1:0] REG_RIGHT_DZ = 2'd2;

  localparam logic [7:0]  RST_TRIG_THR = 8'd30;
  localparam logic [14:0] RST_LEFT_DZ  = 15'd7849;
  localparam logic [14:0] RST_RIGHT_DZ = 15'd8689;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRG_SETUP,
    S_TRG_DIV,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_DZ,
    S_CMP,
    S_SQRT,
    S_SPAN,
    S_DEN,
    S_AX_DIV,
    S_AX_WAIT,
    S_AY_DIV,
    S_AY_WAIT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_res_t;

endpackage
`default_nettype wire

// ===== rtl/gic_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on gic_pkg for widths and the result struct.
`default_nettype none
module gic_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gic_pkg::NUM_W-1:0]  num,
  input  logic [gic_pkg::DEN_W-1:0]  den,
  output gic_pkg::div_res_t          res
);

  localparam int NW    = gic_pkg::NUM_W;
  localparam int DW    = gic_pkg::DEN_W;
  localparam int QW    = gic_pkg::QUOT_W;
  localparam int HI_W  = NW - QW;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    den_q;
  logic [QW-1:0]    shf;
  logic [QW-1:0]    quot;
  logic             ovf;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic [DW-1:0]    num_hi;

  assign num_hi = {{(DW-HI_W){1'b0}}, num[NW-1:QW]};
  assign trial  = {rem, shf[QW-1]};
  assign diff   = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QW);
    end else if (busy) begin
      if (cnt == '0) busy <= 1'b0;
      else cnt <= cnt - 1'b1;
    end
  end

  // divisor held for the whole division
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num_hi;
      den_q <= den;
      shf   <= num[QW-1:0];
      ovf   <= (num_hi >= den);
      quot  <= '0;
    end else if (busy && cnt != '0) begin
      if (!diff[DW]) begin
        rem  <= diff[DW-1:0];
        quot <= {quot[QW-2:0], 1'b1};
      end else begin
        rem  <= trial[DW-1:0];
        quot <= {quot[QW-2:0], 1'b0};
      end
      shf <= {shf[QW-2:0], 1'b0};
    end
  end

  assign res.done = busy && (cnt == '0);
  assign res.ovf  = ovf;
  assign res.quot = quot;

endmodule
`default_nettype wire

// ===== rtl/gic_sqrt.sv =====
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on gic_pkg for widths and the result struct.
`default_nettype none
module gic_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gic_pkg::RAD_W-1:0]  radicand,
  output gic_pkg::sqrt_res_t         res
);

  localparam int RW    = gic_pkg::RAD_W;
  localparam int QW    = gic_pkg::ROOT_W;
  localparam int REMW  = QW + 3;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RW-1:0]    shf;
  logic [QW-1:0]    root;
  logic [REMW-1:0]  rem;
  logic [REMW-1:0]  trial_rem;
  logic [REMW-1:0]  trial_sub;
  logic [REMW:0]    diff;

  assign trial_rem = {rem[REMW-3:0], shf[RW-1:RW-2]};
  assign trial_sub = {1'b0, root, 2'b01};
  assign diff      = {1'b0, trial_rem} - {1'b0, trial_sub};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QW);
    end else if (busy) begin
      if (cnt == '0) busy <= 1'b0;
      else cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shf  <= radicand;
      root <= '0;
      rem  <= '0;
    end else if (busy && cnt != '0) begin
      if (!diff[REMW]) begin
        rem  <= diff[REMW-1:0];
        root <= {root[QW-2:0], 1'b1};
      end else begin
        rem  <= trial_rem;
        root <= {root[QW-2:0], 1'b0};
      end
      shf <= {shf[RW-3:0], 2'b00};
    end
  end

  assign res.done = busy && (cnt == '0);
  assign res.root = root;

endmodule
`default_nettype wire

// ===== rtl/gamepad_input_conditioner.sv =====
// Gamepad input conditioner top level: APB registers, per-pad held flags,
// sequencer, shared multiplier. Depends on gic_pkg, gic_div, gic_sqrt.
//
// One report is taken at a time. Button, trigger-held and direction flags are
// settled when the item is accepted; the trigger levels and the two stick
// vectors then go through one shared 24x16 multiplier, one bit-serial divider
// (up to six quotients) and one square-root unit (up to two roots). An item
// finishes sooner when a trigger is released or a stick is inside its
// deadzone. The next item is taken as soon as the result sits in the output
// register, even if it has not been collected yet.
`default_nettype none
module gamepad_input_conditioner (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gic_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [gic_pkg::PAD_W-1:0]    pad_index,
  input  logic [15:0]                  button_bits,
  input  logic [7:0]                   left_trigger,
  input  logic [7:0]                   right_trigger,
  input  logic signed [15:0]           left_x,
  input  logic signed [15:0]           left_y,
  input  logic signed [15:0]           right_x,
  input  logic signed [15:0]           right_y,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [15:0]                  buttons_held,
  output logic [15:0]                  buttons_pressed,
  output logic [3:0]                   trigger_flags,
  output logic [14:0]                  left_trigger_level,
  output logic [14:0]                  right_trigger_level,
  output logic signed [15:0]           left_stick_x,
  output logic signed [15:0]           left_stick_y,
  output logic signed [15:0]           right_stick_x,
  output logic signed [15:0]           right_stick_y,
  output logic [7:0]                   direction_held,
  output logic [7:0]                   direction_pressed
);

  localparam int NW = gic_pkg::NUM_W;
  localparam int DW = gic_pkg::DEN_W;
  localparam int QW = gic_pkg::QUOT_W;

  function automatic logic [15:0] abs16(input logic [15:0] v);
    abs16 = v[15] ? (16'd0 - v) : v;
  endfunction

  function automatic logic [3:0] dirs(input logic [15:0] x, input logic [15:0] y,
                                      input logic [14:0] dz);
    logic signed [16:0] sx, sy, pd, nd;
    sx = $signed({x[15], x});
    sy = $signed({y[15], y});
    pd = $signed({2'b00, dz});
    nd = -pd;
    dirs = {sx > pd, sx < nd, sy < nd, sy > pd};
  endfunction

  function automatic logic [15:0] sat_axis(input logic [QW-1:0] q, input logic ovf,
                                           input logic neg);
    logic big_pos, big_neg;
    big_pos = ovf || (q > QW'(32767));
    big_neg = ovf || (q > QW'(32768));
    if (neg) sat_axis = big_neg ? 16'h8000 : (16'd0 - q[15:0]);
    else     sat_axis = big_pos ? 16'h7FFF : q[15:0];
  endfunction

  function automatic logic [14:0] sat_level(input logic [QW-1:0] q, input logic ovf);
    sat_level = (ovf || q > QW'(32767)) ? gic_pkg::FULL_SCALE : q[14:0];
  endfunction

  // registers
  logic [7:0]  thr;
  logic [14:0] dz_l, dz_r;
  logic [23:0] pad_state [gic_pkg::NUM_PADS];

  gic_pkg::seq_state_t state, state_next;
  logic sel, sel_next;

  logic [7:0]  lt, rt;
  logic [15:0] lx, ly, rx, ry;
  logic [15:0] r_held, r_pressed;
  logic [3:0]  r_trg;
  logic [7:0]  r_dir, r_dirp;
  logic [14:0] lvl_l, lvl_r;
  logic [15:0] stk_lx, stk_ly, stk_rx, stk_ry;
  logic [31:0] acc;
  logic [39:0] prod;
  logic [23:0] mag;
  logic [22:0] span;
  logic [39:0] den;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= gic_pkg::RST_TRIG_THR;
      dz_l <= gic_pkg::RST_LEFT_DZ;
      dz_r <= gic_pkg::RST_RIGHT_DZ;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        gic_pkg::REG_TRIG_THR: thr  <= pwdata[7:0];
        gic_pkg::REG_LEFT_DZ:  dz_l <= pwdata[14:0];
        gic_pkg::REG_RIGHT_DZ: dz_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      gic_pkg::REG_TRIG_THR: prdata = {24'd0, thr};
      gic_pkg::REG_LEFT_DZ:  prdata = {17'd0, dz_l};
      gic_pkg::REG_RIGHT_DZ: prdata = {17'd0, dz_r};
      default:               prdata = 32'd0;
    endcase
  end

  // accept-time flags
  logic        accept, pad_ok;
  logic [23:0] prev, new_flags;
  logic [15:0] btn, prev_btn;
  logic [1:0]  trg;
  logic [7:0]  dir;

  assign item_ready = (state == gic_pkg::S_IDLE);
  assign accept     = item_valid && item_ready;
  assign pad_ok     = int'(pad_index) < gic_pkg::NUM_PADS;
  assign prev       = pad_ok ? pad_state[pad_index] : 24'd0;
  assign btn        = button_bits & gic_pkg::BUTTON_MASK;
  assign prev_btn   = {prev[13:10], 2'b00, prev[9:0]};
  assign trg        = {right_trigger >= thr, left_trigger >= thr};
  assign dir        = {dirs(right_x, right_y, dz_r), dirs(left_x, left_y, dz_l)};
  assign new_flags  = {dir, trg, btn[15:12], btn[9:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gic_pkg::NUM_PADS; i++) pad_state[i] <= 24'd0;
    end else if (accept && pad_ok) begin
      pad_state[pad_index] <= new_flags;
    end
  end

  // per-side selection
  logic [15:0] cur_x, cur_y, ax, ay;
  logic [14:0] dz;
  logic        x_neg, y_neg;
  logic [7:0]  tv, trig_den, trig_diff;
  logic        trig_held;
  logic [NW-1:0] trig_num, stick_num;
  logic        stick_dead;
  logic [22:0] m23, dz8;

  assign cur_x     = sel ? rx : lx;
  assign cur_y     = sel ? ry : ly;
  assign dz        = sel ? dz_r : dz_l;
  assign ax        = abs16(cur_x);
  assign ay        = abs16(cur_y);
  assign x_neg     = cur_x[15];
  assign y_neg     = !cur_y[15] && (cur_y != 16'd0);
  assign tv        = sel ? rt : lt;
  assign trig_held = tv >= thr;
  assign trig_den  = 8'd255 - thr;
  assign trig_diff = tv - thr;
  assign trig_num  = {{(NW-23){1'b0}}, trig_diff, 15'd0}
                   + {{(NW-7){1'b0}}, trig_den[7:1]};
  assign stick_num = {1'b0, prod[38:0], 15'd0} + {{(NW-39){1'b0}}, den[39:1]};
  assign stick_dead = (dz == gic_pkg::FULL_SCALE) || (acc <= prod[31:0]);
  assign m23       = (mag > 24'h7FFF00) ? 23'h7FFF00 : mag[22:0];
  assign dz8       = {dz, 8'd0};

  // shared units
  logic                 div_start, sqrt_start;
  logic [NW-1:0]        div_num;
  logic [DW-1:0]        div_den;
  gic_pkg::div_res_t    dres;
  gic_pkg::sqrt_res_t   sres;

  assign div_start  = (state == gic_pkg::S_TRG_SETUP && trig_held && trig_den != 8'd0)
                   || state == gic_pkg::S_AX_DIV || state == gic_pkg::S_AY_DIV;
  assign div_num    = (state == gic_pkg::S_TRG_SETUP) ? trig_num : stick_num;
  assign div_den    = (state == gic_pkg::S_TRG_SETUP) ? {32'd0, trig_den} : den;
  assign sqrt_start = (state == gic_pkg::S_CMP) && !stick_dead;

  gic_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (dres)
  );

  gic_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({acc, 16'd0}),
    .res      (sres)
  );

  // multiplier operands
  logic [23:0] mul_a;
  logic [15:0] mul_b;

  always_comb begin
    unique case (state)
      gic_pkg::S_SQ_X:    begin mul_a = {8'd0, ax};     mul_b = ax; end
      gic_pkg::S_SQ_Y:    begin mul_a = {8'd0, ay};     mul_b = ay; end
      gic_pkg::S_SQ_DZ:   begin mul_a = {9'd0, dz};     mul_b = {1'b0, dz}; end
      gic_pkg::S_SPAN:    begin mul_a = mag;            mul_b = {1'b0, gic_pkg::FULL_SCALE - dz}; end
      gic_pkg::S_DEN:     begin mul_a = {1'b0, span};   mul_b = ax; end
      gic_pkg::S_AX_WAIT: begin mul_a = {1'b0, span};   mul_b = ay; end
      default:            begin mul_a = 24'd0;          mul_b = 16'd0; end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gic_pkg::S_IDLE;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  logic out_free;
  assign out_free = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    sel_next   = sel;
    unique case (state)
      gic_pkg::S_IDLE: begin
        if (item_valid) begin
          state_next = gic_pkg::S_TRG_SETUP;
          sel_next   = 1'b0;
        end
      end
      gic_pkg::S_TRG_SETUP: begin
        if (div_start) state_next = gic_pkg::S_TRG_DIV;
        else if (!sel) sel_next = 1'b1;
        else begin
          sel_next   = 1'b0;
          state_next = gic_pkg::S_SQ_X;
        end
      end
      gic_pkg::S_TRG_DIV: begin
        if (dres.done) begin
          if (!sel) begin
            sel_next   = 1'b1;
            state_next = gic_pkg::S_TRG_SETUP;
          end else begin
            sel_next   = 1'b0;
            state_next = gic_pkg::S_SQ_X;
          end
        end
      end
      gic_pkg::S_SQ_X:  state_next = gic_pkg::S_SQ_Y;
      gic_pkg::S_SQ_Y:  state_next = gic_pkg::S_SQ_DZ;
      gic_pkg::S_SQ_DZ: state_next = gic_pkg::S_CMP;
      gic_pkg::S_CMP: begin
        if (!stick_dead) state_next = gic_pkg::S_SQRT;
        else if (!sel) begin
          sel_next   = 1'b1;
          state_next = gic_pkg::S_SQ_X;
        end else state_next = gic_pkg::S_DONE;
      end
      gic_pkg::S_SQRT: begin
        if (sres.done) state_next = gic_pkg::S_SPAN;
      end
      gic_pkg::S_SPAN: begin
        if (m23 > dz8) state_next = gic_pkg::S_DEN;
        else if (!sel) begin
          sel_next   = 1'b1;
          state_next = gic_pkg::S_SQ_X;
        end else state_next = gic_pkg::S_DONE;
      end
      gic_pkg::S_DEN:    state_next = gic_pkg::S_AX_DIV;
      gic_pkg::S_AX_DIV: state_next = gic_pkg::S_AX_WAIT;
      gic_pkg::S_AX_WAIT: begin
        if (dres.done) state_next = gic_pkg::S_AY_DIV;
      end
      gic_pkg::S_AY_DIV: state_next = gic_pkg::S_AY_WAIT;
      gic_pkg::S_AY_WAIT: begin
        if (dres.done) begin
          if (!sel) begin
            sel_next   = 1'b1;
            state_next = gic_pkg::S_SQ_X;
          end else state_next = gic_pkg::S_DONE;
        end
      end
      gic_pkg::S_DONE: begin
        if (out_free) state_next = gic_pkg::S_IDLE;
      end
      default: state_next = gic_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      gic_pkg::S_IDLE: begin
        if (item_valid) begin
          lt        <= left_trigger;
          rt        <= right_trigger;
          lx        <= left_x;
          ly        <= left_y;
          rx        <= right_x;
          ry        <= right_y;
          r_held    <= btn;
          r_pressed <= btn & ~prev_btn;
          r_trg     <= {trg & ~prev[15:14], trg};
          r_dir     <= dir;
          r_dirp    <= dir & ~prev[23:16];
        end
      end
      gic_pkg::S_TRG_SETUP: begin
        if (!trig_held) begin
          if (!sel) lvl_l <= 15'd0;
          else      lvl_r <= 15'd0;
        end else if (trig_den == 8'd0) begin
          if (!sel) lvl_l <= gic_pkg::FULL_SCALE;
          else      lvl_r <= gic_pkg::FULL_SCALE;
        end
      end
      gic_pkg::S_TRG_DIV: begin
        if (dres.done) begin
          if (!sel) lvl_l <= sat_level(dres.quot, dres.ovf);
          else      lvl_r <= sat_level(dres.quot, dres.ovf);
        end
      end
      gic_pkg::S_SQ_Y:  acc <= prod[31:0];
      gic_pkg::S_SQ_DZ: acc <= acc + prod[31:0];
      gic_pkg::S_CMP: begin
        if (stick_dead) begin
          if (!sel) begin stk_lx <= 16'd0; stk_ly <= 16'd0; end
          else      begin stk_rx <= 16'd0; stk_ry <= 16'd0; end
        end
      end
      gic_pkg::S_SQRT: begin
        if (sres.done) mag <= sres.root;
      end
      gic_pkg::S_SPAN: begin
        if (m23 > dz8) span <= m23 - dz8;
        else if (!sel) begin stk_lx <= 16'd0; stk_ly <= 16'd0; end
        else           begin stk_rx <= 16'd0; stk_ry <= 16'd0; end
      end
      gic_pkg::S_DEN: den <= prod;
      gic_pkg::S_AX_WAIT: begin
        if (dres.done) begin
          if (!sel) stk_lx <= sat_axis(dres.quot, dres.ovf, x_neg);
          else      stk_rx <= sat_axis(dres.quot, dres.ovf, x_neg);
        end
      end
      gic_pkg::S_AY_WAIT: begin
        if (dres.done) begin
          if (!sel) stk_ly <= sat_axis(dres.quot, dres.ovf, y_neg);
          else      stk_ry <= sat_axis(dres.quot, dres.ovf, y_neg);
        end
      end
      default: ;
    endcase
  end

  // output register
  logic load_out;
  assign load_out = (state == gic_pkg::S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (load_out) result_valid <= 1'b1;
    else if (result_ready) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      buttons_held        <= r_held;
      buttons_pressed     <= r_pressed;
      trigger_flags       <= r_trg;
      left_trigger_level  <= lvl_l;
      right_trigger_level <= lvl_r;
      left_stick_x        <= stk_lx;
      left_stick_y        <= stk_ly;
      right_stick_x       <= stk_rx;
      right_stick_y       <= stk_ry;
      direction_held      <= r_dir;
      direction_pressed   <= r_dirp;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gic_checker.sv =====
// Port-level checks for the gamepad input conditioner, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module gic_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [15:0] buttons_held,
  input logic [15:0] buttons_pressed,
  input logic [3:0]  trigger_flags,
  input logic [15:0] left_stick_x,
  input logic [7:0]  direction_held,
  input logic [7:0]  direction_pressed
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(buttons_held)
      && $stable(left_stick_x))
    else $error("result changed while stalled");

  a_btn_mask: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (buttons_held & 16'h0C00) == 16'h0000
      && (buttons_pressed & ~buttons_held) == 16'h0000)
    else $error("button flags inconsistent");

  a_trg: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (trigger_flags[3:2] & ~trigger_flags[1:0]) == 2'b00)
    else $error("trigger pressed without held");

  a_dir: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (direction_pressed & ~direction_held) == 8'h00
      && !(direction_held[0] && direction_held[1])
      && !(direction_held[4] && direction_held[5]))
    else $error("direction flags inconsistent");

endmodule

bind gamepad_input_conditioner gic_checker u_gic_checker (.*);
`default_nettype wire
